// ===== rtl/ypfc_pkg.sv =====
// ypfc_pkg: shared types and constants for the yaw/pitch fly camera.
// Holds the sequencer state type, register indexes and the CORDIC arctangent table.
// No dependencies.
package ypfc_pkg;

  localparam logic [1:0] CFG_MOVE_GAIN   = 2'd0;
  localparam logic [1:0] CFG_LOOK_SENS   = 2'd1;
  localparam logic [1:0] CFG_PITCH_LIMIT = 2'd2;

  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;

  localparam logic [1:0] VEC_FRONT = 2'd0;
  localparam logic [1:0] VEC_RIGHT = 2'd1;
  localparam logic [1:0] VEC_UP    = 2'd2;

  localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [22:0] YAW_SPAN     = 23'sd92160;
  localparam logic signed [22:0] YAW_HALF     = 23'sd46080;
  localparam logic signed [25:0] DEG90_Q16    = 26'sd5898240;
  localparam logic signed [25:0] DEG180_Q16   = 26'sd11796480;

  typedef enum logic [26:0] {
    S_IDLE      = 27'h0000001,
    S_MV_ADJ    = 27'h0000002,
    S_MV_LAT    = 27'h0000004,
    S_MV_MUL    = 27'h0000008,
    S_MV_ACC    = 27'h0000010,
    S_LK_MULX   = 27'h0000020,
    S_LK_MULY   = 27'h0000040,
    S_LK_UPD    = 27'h0000080,
    S_YAW_WRAP  = 27'h0000100,
    S_TRIG_LOAD = 27'h0000200,
    S_TRIG_RED  = 27'h0000400,
    S_TRIG_ROT  = 27'h0000800,
    S_TRIG_DONE = 27'h0001000,
    S_FR_MUL0   = 27'h0002000,
    S_FR_MUL1   = 27'h0004000,
    S_FR_MUL2   = 27'h0008000,
    S_UN_SQ     = 27'h0010000,
    S_UN_ACC    = 27'h0020000,
    S_UN_SQRT   = 27'h0040000,
    S_UN_CHK    = 27'h0080000,
    S_DIV_INIT  = 27'h0100000,
    S_UN_DIV    = 27'h0200000,
    S_UN_STORE  = 27'h0400000,
    S_UN_COMMIT = 27'h0800000,
    S_UP_MUL    = 27'h1000000,
    S_UP_ACC    = 27'h2000000,
    S_FIN       = 27'h4000000
  } state_t;

  // arctangent of 2^-i in Q.16 degrees
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117305;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/yaw_pitch_fly_camera.sv =====
// yaw_pitch_fly_camera: Euler-angle fly camera, position and unit vectors.
// One shared multiplier plus CORDIC, square-root and divide steps under a sequencer.
// Depends on ypfc_pkg.
//
//  channel | direction | handshake       | payload
//  in_     | input     | in_valid/stall  | kind, direction, speed, x/y_offset, clamp_pitch
//  out_    | output    | out_valid/stall | pos_x..z, front_x..z, right_x..z, up_x..z
//  cfg_    | input     | valid/ready     | index (2 bit), data (16 bit)
//
// A look item runs two CORDIC runs (TRIG_STEPS steps each) and three normalizations
// of 32 square-root steps and three 15-step divides each. in_stall is high while
// an item is in work.
// The result register frees the core; a stalled result holds the core in its last state.
// Reset (synchronous rst_n) loads the initial camera and register values.
module yaw_pitch_fly_camera #(
  parameter int TRIG_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [1:0]         in_direction,
  input  logic [15:0]        in_speed,
  input  logic signed [15:0] in_x_offset,
  input  logic signed [15:0] in_y_offset,
  input  logic               in_clamp_pitch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_y,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  ypfc_pkg::state_t state_r;

  logic [15:0] gain_r, sens_r;
  logic [14:0] limit_r;

  logic               clamp_r;
  logic [1:0]         dir_r;
  logic [15:0]        speed_r;
  logic signed [15:0] xo_r, yo_r;

  logic signed [18:0] yaw_r, pitch_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r [3];
  logic signed [15:0] new_r [3];

  logic [1:0] k_r, vec_sel_r;
  logic [4:0] step_r;
  logic       ang_sel_r, flip_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  logic [31:0]        adj_r;
  logic signed [20:0] dx_r;
  logic signed [22:0] wrap_r;
  logic signed [21:0] red_r;
  logic signed [25:0] ang_r;
  logic signed [32:0] x_r, y_r;
  logic signed [32:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [32:0] raw_r [3];
  logic [63:0]        ss_r, sq_n_r, sq_r, sq_b_r;
  logic [31:0]        len_r;
  logic [46:0]        num_r;
  logic [14:0]        q_r;

  logic               out_valid_r;
  logic signed [31:0] o_pos_r [3];
  logic signed [15:0] o_front_r [3];
  logic signed [15:0] o_right_r [3];
  logic signed [15:0] o_up_r [3];

  // combinational helpers
  logic signed [15:0] mv_vec;
  logic               mv_neg;
  logic signed [65:0] mv_round, lk_round, fr_round;
  logic signed [33:0] mv_sum;
  logic signed [31:0] mv_sat;
  logic signed [21:0] p_sum;
  logic signed [18:0] p_sat, p_fin;
  logic signed [18:0] lim_s;
  logic signed [25:0] red_sh, atan_s;
  logic signed [32:0] cx_sh, cy_sh;
  logic [31:0]        mag;
  logic [63:0]        ss_new, sq_trial;
  logic [46:0]        div_trial;
  logic signed [32:0] up_term;
  logic [2:0]         up_j;
  logic               trig_last;

  assign in_stall  = (state_r != ypfc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  assign out_pos_x   = o_pos_r[0];
  assign out_pos_y   = o_pos_r[1];
  assign out_pos_z   = o_pos_r[2];
  assign out_front_x = o_front_r[0];
  assign out_front_y = o_front_r[1];
  assign out_front_z = o_front_r[2];
  assign out_right_x = o_right_r[0];
  assign out_right_y = o_right_r[1];
  assign out_right_z = o_right_r[2];
  assign out_up_x    = o_up_r[0];
  assign out_up_y    = o_up_r[1];
  assign out_up_z    = o_up_r[2];

  assign trig_last = (step_r == 5'(TRIG_STEPS - 1));
  assign up_j      = step_r[2:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ypfc_pkg::S_MV_ADJ: begin
        mul_a = 33'($unsigned(speed_r));
        mul_b = 33'($unsigned(gain_r));
      end
      ypfc_pkg::S_MV_MUL: begin
        mul_a = $signed({1'b0, adj_r});
        mul_b = 33'(mv_vec);
      end
      ypfc_pkg::S_LK_MULX: begin
        mul_a = 33'(xo_r);
        mul_b = 33'($unsigned(sens_r));
      end
      ypfc_pkg::S_LK_MULY: begin
        mul_a = 33'(yo_r);
        mul_b = 33'($unsigned(sens_r));
      end
      ypfc_pkg::S_FR_MUL0: begin
        mul_a = cy_r;
        mul_b = cp_r;
      end
      ypfc_pkg::S_FR_MUL1: begin
        mul_a = sy_r;
        mul_b = cp_r;
      end
      ypfc_pkg::S_UN_SQ: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({1'b0, mag});
      end
      ypfc_pkg::S_UP_MUL: begin
        case (up_j)
          3'd0: begin mul_a = 33'(right_r[1]); mul_b = 33'(front_r[2]); end
          3'd1: begin mul_a = 33'(right_r[2]); mul_b = 33'(front_r[1]); end
          3'd2: begin mul_a = 33'(right_r[2]); mul_b = 33'(front_r[0]); end
          3'd3: begin mul_a = 33'(right_r[0]); mul_b = 33'(front_r[2]); end
          3'd4: begin mul_a = 33'(right_r[0]); mul_b = 33'(front_r[1]); end
          default: begin mul_a = 33'(right_r[1]); mul_b = 33'(front_r[0]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mv_vec   = (dir_r[1] == 1'b0) ? front_r[k_r] : right_r[k_r];
    mv_neg   = (dir_r == ypfc_pkg::DIR_BACK) || (dir_r == ypfc_pkg::DIR_LEFT);
    mv_round = (prod_r + 66'sd2097152) >>> 22;
    mv_sum   = mv_neg ? (34'(pos_r[k_r]) - mv_round[33:0])
                      : (34'(pos_r[k_r]) + mv_round[33:0]);
    if (mv_sum > 34'sd2147483647) mv_sat = 32'sh7fffffff;
    else if (mv_sum < -34'sd2147483648) mv_sat = 32'sh80000000;
    else mv_sat = mv_sum[31:0];

    lk_round = (prod_r + 66'sd2048) >>> 12;
    p_sum    = 22'(pitch_r) + lk_round[21:0];
    if (p_sum > 22'sd262143) p_sat = 19'sd262143;
    else if (p_sum < -22'sd262144) p_sat = -19'sd262144;
    else p_sat = p_sum[18:0];
    lim_s = $signed({4'b0000, limit_r});
    p_fin = p_sat;
    if (clamp_r) begin
      if (p_sat > lim_s) p_fin = lim_s;
      else if (p_sat < -lim_s) p_fin = -lim_s;
    end

    fr_round = (prod_r + 66'sd536870912) >>> 30;

    red_sh = 26'(red_r) <<< 8;
    atan_s = $signed(26'(ypfc_pkg::atan_q16(step_r)));
    cx_sh  = y_r >>> step_r;
    cy_sh  = x_r >>> step_r;

    mag = raw_r[k_r][32] ? 32'(-raw_r[k_r]) : 32'(raw_r[k_r]);
    ss_new    = ((k_r == 2'd0) ? 64'd0 : ss_r) + prod_r[63:0];
    sq_trial  = sq_r + sq_b_r;
    div_trial = 47'(len_r) << step_r;
    up_term   = prod_r[32:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= ypfc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= 16'd8192;
      sens_r      <= 16'd6554;
      limit_r     <= 15'd22784;
      yaw_r       <= -19'sd23040;
      pitch_r     <= '0;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= 32'sd327680;
      front_r[0]  <= '0;
      front_r[1]  <= '0;
      front_r[2]  <= -16'sd16384;
      right_r[0]  <= 16'sd16384;
      right_r[1]  <= '0;
      right_r[2]  <= '0;
      up_r[0]     <= '0;
      up_r[1]     <= 16'sd16384;
      up_r[2]     <= '0;
      k_r         <= '0;
      step_r      <= '0;
      vec_sel_r   <= ypfc_pkg::VEC_FRONT;
      ang_sel_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ypfc_pkg::CFG_MOVE_GAIN:   gain_r  <= cfg_data;
          ypfc_pkg::CFG_LOOK_SENS:   sens_r  <= cfg_data;
          ypfc_pkg::CFG_PITCH_LIMIT: limit_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != ypfc_pkg::S_FIN)) out_valid_r <= 1'b0;

      case (state_r)
        ypfc_pkg::S_IDLE: begin
          if (in_valid) begin
            dir_r   <= in_direction;
            speed_r <= in_speed;
            xo_r    <= in_x_offset;
            yo_r    <= in_y_offset;
            clamp_r <= in_clamp_pitch;
            k_r     <= '0;
            state_r <= in_kind ? ypfc_pkg::S_LK_MULX : ypfc_pkg::S_MV_ADJ;
          end
        end
        ypfc_pkg::S_MV_ADJ: state_r <= ypfc_pkg::S_MV_LAT;
        ypfc_pkg::S_MV_LAT: begin
          adj_r   <= prod_r[31:0];
          state_r <= ypfc_pkg::S_MV_MUL;
        end
        ypfc_pkg::S_MV_MUL: state_r <= ypfc_pkg::S_MV_ACC;
        ypfc_pkg::S_MV_ACC: begin
          pos_r[k_r] <= mv_sat;
          k_r        <= k_r + 2'd1;
          state_r    <= (k_r == 2'd2) ? ypfc_pkg::S_FIN : ypfc_pkg::S_MV_MUL;
        end
        ypfc_pkg::S_LK_MULX: state_r <= ypfc_pkg::S_LK_MULY;
        ypfc_pkg::S_LK_MULY: begin
          dx_r    <= lk_round[20:0];
          state_r <= ypfc_pkg::S_LK_UPD;
        end
        ypfc_pkg::S_LK_UPD: begin
          wrap_r  <= 23'(yaw_r) + 23'(dx_r) + ypfc_pkg::YAW_HALF;
          pitch_r <= p_fin;
          state_r <= ypfc_pkg::S_YAW_WRAP;
        end
        ypfc_pkg::S_YAW_WRAP: begin
          if (wrap_r < 0) begin
            wrap_r <= wrap_r + ypfc_pkg::YAW_SPAN;
          end else if (wrap_r >= ypfc_pkg::YAW_SPAN) begin
            wrap_r <= wrap_r - ypfc_pkg::YAW_SPAN;
          end else begin
            yaw_r     <= 19'(wrap_r - ypfc_pkg::YAW_HALF);
            ang_sel_r <= 1'b0;
            state_r   <= ypfc_pkg::S_TRIG_LOAD;
          end
        end
        ypfc_pkg::S_TRIG_LOAD: begin
          red_r   <= ang_sel_r ? 22'(pitch_r) : 22'(yaw_r);
          state_r <= ypfc_pkg::S_TRIG_RED;
        end
        ypfc_pkg::S_TRIG_RED: begin
          if (red_r < -22'(ypfc_pkg::YAW_HALF)) begin
            red_r <= red_r + 22'(ypfc_pkg::YAW_SPAN);
          end else if (red_r >= 22'(ypfc_pkg::YAW_HALF)) begin
            red_r <= red_r - 22'(ypfc_pkg::YAW_SPAN);
          end else begin
            if (red_sh > ypfc_pkg::DEG90_Q16) begin
              ang_r  <= ypfc_pkg::DEG180_Q16 - red_sh;
              flip_r <= 1'b1;
            end else if (red_sh < -ypfc_pkg::DEG90_Q16) begin
              ang_r  <= -ypfc_pkg::DEG180_Q16 - red_sh;
              flip_r <= 1'b1;
            end else begin
              ang_r  <= red_sh;
              flip_r <= 1'b0;
            end
            x_r     <= ypfc_pkg::INV_GAIN_Q30;
            y_r     <= '0;
            step_r  <= '0;
            state_r <= ypfc_pkg::S_TRIG_ROT;
          end
        end
        ypfc_pkg::S_TRIG_ROT: begin
          if (ang_r >= 0) begin
            x_r   <= x_r - cx_sh;
            y_r   <= y_r + cy_sh;
            ang_r <= ang_r - atan_s;
          end else begin
            x_r   <= x_r + cx_sh;
            y_r   <= y_r - cy_sh;
            ang_r <= ang_r + atan_s;
          end
          step_r <= step_r + 5'd1;
          if (trig_last) state_r <= ypfc_pkg::S_TRIG_DONE;
        end
        ypfc_pkg::S_TRIG_DONE: begin
          if (!ang_sel_r) begin
            sy_r      <= y_r;
            cy_r      <= flip_r ? -x_r : x_r;
            ang_sel_r <= 1'b1;
            state_r   <= ypfc_pkg::S_TRIG_LOAD;
          end else begin
            sp_r    <= y_r;
            cp_r    <= flip_r ? -x_r : x_r;
            state_r <= ypfc_pkg::S_FR_MUL0;
          end
        end
        ypfc_pkg::S_FR_MUL0: state_r <= ypfc_pkg::S_FR_MUL1;
        ypfc_pkg::S_FR_MUL1: begin
          raw_r[0] <= fr_round[32:0];
          state_r  <= ypfc_pkg::S_FR_MUL2;
        end
        ypfc_pkg::S_FR_MUL2: begin
          raw_r[1]  <= sp_r;
          raw_r[2]  <= fr_round[32:0];
          vec_sel_r <= ypfc_pkg::VEC_FRONT;
          k_r       <= '0;
          state_r   <= ypfc_pkg::S_UN_SQ;
        end
        ypfc_pkg::S_UN_SQ: state_r <= ypfc_pkg::S_UN_ACC;
        ypfc_pkg::S_UN_ACC: begin
          ss_r <= ss_new;
          if (k_r == 2'd2) begin
            k_r     <= '0;
            sq_n_r  <= ss_new;
            sq_r    <= '0;
            sq_b_r  <= 64'd1 << 62;
            step_r  <= '0;
            state_r <= ypfc_pkg::S_UN_SQRT;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= ypfc_pkg::S_UN_SQ;
          end
        end
        ypfc_pkg::S_UN_SQRT: begin
          if (sq_n_r >= sq_trial) begin
            sq_n_r <= sq_n_r - sq_trial;
            sq_r   <= (sq_r >> 1) + sq_b_r;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b_r <= sq_b_r >> 2;
          step_r <= step_r + 5'd1;
          if (step_r == 5'd31) state_r <= ypfc_pkg::S_UN_CHK;
        end
        ypfc_pkg::S_UN_CHK: begin
          len_r   <= sq_r[31:0];
          k_r     <= '0;
          state_r <= (sq_r == 64'd0) ? ypfc_pkg::S_FIN : ypfc_pkg::S_DIV_INIT;
        end
        ypfc_pkg::S_DIV_INIT: begin
          num_r   <= (47'(mag) << 14) + 47'(len_r >> 1);
          q_r     <= '0;
          step_r  <= 5'd14;
          state_r <= ypfc_pkg::S_UN_DIV;
        end
        ypfc_pkg::S_UN_DIV: begin
          if (num_r >= div_trial) begin
            num_r <= num_r - div_trial;
            q_r   <= q_r | (15'd1 << step_r);
          end
          step_r <= step_r - 5'd1;
          if (step_r == 5'd0) state_r <= ypfc_pkg::S_UN_STORE;
        end
        ypfc_pkg::S_UN_STORE: begin
          new_r[k_r] <= raw_r[k_r][32] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
          k_r        <= k_r + 2'd1;
          state_r    <= (k_r == 2'd2) ? ypfc_pkg::S_UN_COMMIT : ypfc_pkg::S_DIV_INIT;
        end
        ypfc_pkg::S_UN_COMMIT: begin
          k_r <= '0;
          case (vec_sel_r)
            ypfc_pkg::VEC_FRONT: begin
              front_r[0] <= new_r[0];
              front_r[1] <= new_r[1];
              front_r[2] <= new_r[2];
              raw_r[0]   <= -33'(new_r[2]);
              raw_r[1]   <= '0;
              raw_r[2]   <= 33'(new_r[0]);
              vec_sel_r  <= ypfc_pkg::VEC_RIGHT;
              state_r    <= ypfc_pkg::S_UN_SQ;
            end
            ypfc_pkg::VEC_RIGHT: begin
              right_r[0] <= new_r[0];
              right_r[1] <= new_r[1];
              right_r[2] <= new_r[2];
              step_r     <= '0;
              state_r    <= ypfc_pkg::S_UP_MUL;
            end
            default: begin
              up_r[0] <= new_r[0];
              up_r[1] <= new_r[1];
              up_r[2] <= new_r[2];
              state_r <= ypfc_pkg::S_FIN;
            end
          endcase
        end
        ypfc_pkg::S_UP_MUL: state_r <= ypfc_pkg::S_UP_ACC;
        ypfc_pkg::S_UP_ACC: begin
          if (up_j[0]) begin
            raw_r[up_j[2:1]] <= raw_r[up_j[2:1]] - up_term;
          end else begin
            raw_r[up_j[2:1]] <= up_term;
          end
          step_r <= step_r + 5'd1;
          if (up_j == 3'd5) begin
            vec_sel_r <= ypfc_pkg::VEC_UP;
            k_r       <= '0;
            state_r   <= ypfc_pkg::S_UN_SQ;
          end else begin
            state_r <= ypfc_pkg::S_UP_MUL;
          end
        end
        ypfc_pkg::S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            o_pos_r[0]   <= pos_r[0];
            o_pos_r[1]   <= pos_r[1];
            o_pos_r[2]   <= pos_r[2];
            o_front_r[0] <= front_r[0];
            o_front_r[1] <= front_r[1];
            o_front_r[2] <= front_r[2];
            o_right_r[0] <= right_r[0];
            o_right_r[1] <= right_r[1];
            o_right_r[2] <= right_r[2];
            o_up_r[0]    <= up_r[0];
            o_up_r[1]    <= up_r[1];
            o_up_r[2]    <= up_r[2];
            out_valid_r  <= 1'b1;
            state_r      <= ypfc_pkg::S_IDLE;
          end
        end
        default: state_r <= ypfc_pkg::S_IDLE;
      endcase
    end
  end

endmodule
